// ----- hdl/bsm_pkg.sv -----
// ---------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants for the buffer slot manager: slot pool sizes,
// request and status codes, transaction payloads and internal control structs.
// ---------------------------------------------------------------------------
package bsm_pkg;

  // Pool geometry
  localparam int SLOT_COUNT       = 32;
  localparam int IDX_W            = $clog2(SLOT_COUNT);
  localparam int DISK_BLOCK_COUNT = 8192;
  localparam int BLK_W            = 13;
  localparam int AGE_W            = 6;
  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // Request kinds (op field)
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_MARK   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOB  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [1:0]       op;
    logic [BLK_W-1:0] block_num;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]       status;
    logic [4:0]       slot_index;
    logic             writeback_valid;
    logic [BLK_W-1:0] writeback_block;
  } out_item_t;

  // Metadata of one slot as read from the store
  typedef struct packed {
    logic             free;
    logic             dirty;
    logic [AGE_W-1:0] age;
    logic [BLK_W-1:0] tag;
  } slot_view_t;

  // Store write kinds
  typedef enum logic [1:0] {
    WR_NONE,
    WR_AGE,
    WR_DIRTY,
    WR_ALLOC
  } wr_kind_t;

  // One store update per cycle
  typedef struct packed {
    wr_kind_t         kind;
    logic [IDX_W-1:0] idx;
    logic [AGE_W-1:0] age;
    logic [BLK_W-1:0] tag;
  } store_wr_t;

  // Scan accumulator results
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] best_idx;
    logic             best_dirty;
    logic [BLK_W-1:0] best_tag;
  } scan_res_t;

endpackage

// ----- hdl/bsm_slot_store.sv -----
// ---------------------------------------------------------------------------
// bsm_slot_store
// Per-slot metadata: free and dirty flags, ages and block tags. One read
// port at the walk index, one update per cycle.
// ---------------------------------------------------------------------------
module bsm_slot_store
  import bsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  output slot_view_t       rd_view,
  input  store_wr_t        wr
);

  logic [SLOT_COUNT-1:0] free_r;
  logic [SLOT_COUNT-1:0] dirty_r;
  logic [AGE_W-1:0]      age_r [SLOT_COUNT];
  logic [BLK_W-1:0]      tag_r [SLOT_COUNT];

  // Read port
  always_comb begin
    rd_view.free  = free_r[rd_idx];
    rd_view.dirty = dirty_r[rd_idx];
    rd_view.age   = age_r[rd_idx];
    rd_view.tag   = tag_r[rd_idx];
  end

  // Flags and ages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= '1;
      dirty_r <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      unique case (wr.kind)
        WR_AGE: begin
          age_r[wr.idx] <= wr.age;
        end
        WR_DIRTY: begin
          dirty_r[wr.idx] <= 1'b1;
        end
        WR_ALLOC: begin
          free_r[wr.idx]  <= 1'b0;
          dirty_r[wr.idx] <= 1'b0;
          age_r[wr.idx]   <= '0;
        end
        default: ;
      endcase
    end
  end

  // Tags: no reset, only read once the slot is occupied
  always_ff @(posedge clk) begin
    if (wr.kind == WR_ALLOC) begin
      tag_r[wr.idx] <= wr.tag;
    end
  end

endmodule

// ----- hdl/bsm_scan_unit.sv -----
// ---------------------------------------------------------------------------
// bsm_scan_unit
// Shared compare unit stepped once per slot: tag match for lookups, and for
// allocation the saturating age increment, first free slot and oldest slot.
// ---------------------------------------------------------------------------
module bsm_scan_unit
  import bsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             step,
  input  logic             alloc,
  input  logic [BLK_W-1:0] blk,
  input  logic [IDX_W-1:0] idx,
  input  slot_view_t       view,
  output logic [AGE_W-1:0] aged,
  output scan_res_t        res
);

  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [AGE_W-1:0] best_age_r;
  logic [IDX_W-1:0] best_idx_r;
  logic             best_dirty_r;
  logic [BLK_W-1:0] best_tag_r;
  logic             tag_eq;
  logic             older;

  // Compare and saturating increment
  assign tag_eq = !view.free && (view.tag == blk);
  assign aged   = (view.free || view.age == AGE_MAX) ? view.age : view.age + 1'b1;
  assign older  = aged > best_age_r;

  // Accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      best_age_r   <= '0;
      best_idx_r   <= '0;
      best_dirty_r <= 1'b0;
    end else if (clear) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      best_age_r   <= '0;
      best_idx_r   <= '0;
      best_dirty_r <= 1'b0;
    end else if (step) begin
      if (!alloc && tag_eq && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= idx;
      end
      if (alloc && view.free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx;
      end
      // strict compare keeps the lowest index on ties
      if (alloc && older) begin
        best_age_r   <= aged;
        best_idx_r   <= idx;
        best_dirty_r <= view.dirty;
        best_tag_r   <= view.tag;
      end
    end
  end

  assign res.hit        = hit_r;
  assign res.hit_idx    = hit_idx_r;
  assign res.free_found = free_found_r;
  assign res.free_idx   = free_idx_r;
  assign res.best_idx   = best_idx_r;
  assign res.best_dirty = best_dirty_r;
  assign res.best_tag   = best_tag_r;

endmodule

// ----- hdl/buffer_slot_manager_age_evict.sv -----
// ---------------------------------------------------------------------------
// buffer_slot_manager_age_evict
// Buffer pool metadata with lookup, mark-dirty and allocate requests;
// allocation takes the lowest free slot or evicts the oldest one.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------
//   in_     | input     | in_valid/in_stall  | in_item_t (op, block_num)
//   out_    | output    | out_valid/out_stall| out_item_t (status, ...)
//
// Sequence: an in-range request is accepted, walks every slot in turn through
// the shared scan unit, then commits; an out-of-range one goes straight to commit.
// Reset: synchronous rst_n frees all slots and clears dirty flags and ages.
// Stalls: the next request is taken while a result waits in the output
// register; the commit step waits until that register is free.
// ---------------------------------------------------------------------------
module buffer_slot_manager_age_evict
  import bsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  localparam logic [16:0] DISK_LIMIT = 17'(DISK_BLOCK_COUNT);

  state_t           state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic             oob_r, oob_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             in_acc;
  logic             in_oob;
  logic             is_alloc;
  logic             can_load;
  logic             scan_clear;
  logic             scan_step;
  logic [AGE_W-1:0] aged;
  slot_view_t       view;
  scan_res_t        res;
  store_wr_t        wr;
  logic [IDX_W-1:0] pick;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_oob    = (in_data.block_num == '0) || (17'(in_data.block_num) >= DISK_LIMIT);
  assign is_alloc  = (op_r == OP_ALLOC);
  assign can_load  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign scan_clear = in_acc;
  assign scan_step  = (state_r == S_WALK);
  assign pick       = res.free_found ? res.free_idx : res.best_idx;

  bsm_slot_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (idx_r),
    .rd_view (view),
    .wr      (wr)
  );

  bsm_scan_unit u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (scan_clear),
    .step  (scan_step),
    .alloc (is_alloc),
    .blk   (blk_r),
    .idx   (idx_r),
    .view  (view),
    .aged  (aged),
    .res   (res)
  );

  // Sequencer and result formation
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    blk_nxt       = blk_r;
    oob_nxt       = oob_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr            = '{kind: WR_NONE, idx: idx_r, age: aged, tag: blk_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_data.op;
          blk_nxt   = in_data.block_num;
          oob_nxt   = in_oob;
          idx_nxt   = '0;
          state_nxt = in_oob ? S_FINISH : S_WALK;
        end
      end
      S_WALK: begin
        // age occupied slots in place during an allocation walk
        if (is_alloc) begin
          wr.kind = WR_AGE;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_W'(SLOT_COUNT - 1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (oob_r) begin
            out_data_nxt.status = ST_OOB;
          end else if (is_alloc) begin
            wr.kind = WR_ALLOC;
            wr.idx  = pick;
            out_data_nxt.status     = ST_OK;
            out_data_nxt.slot_index = 5'(pick);
            if (!res.free_found && res.best_dirty) begin
              out_data_nxt.writeback_valid = 1'b1;
              out_data_nxt.writeback_block = res.best_tag;
            end
          end else if (!res.hit) begin
            out_data_nxt.status = ST_MISS;
          end else begin
            if (op_r == OP_MARK) begin
              wr.kind = WR_DIRTY;
              wr.idx  = res.hit_idx;
            end
            out_data_nxt.status     = ST_OK;
            out_data_nxt.slot_index = 5'(res.hit_idx);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      oob_r       <= 1'b0;
      op_r        <= OP_LOOKUP;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      oob_r       <= oob_nxt;
      op_r        <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // A new result only ever comes from the commit step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(state_r == S_FINISH))
    else $error("result produced outside commit step");

  // Write-back only reported with a successful allocation
  a_wb_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.writeback_valid) |-> (out_data_r.status == ST_OK))
    else $error("write-back reported on failed request");

  // Failed requests report slot zero
  a_idx_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |-> (out_data_r.slot_index == '0))
    else $error("nonzero slot index on failed request");

  // In-range request starts the walk at slot zero
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_oob) |=> (state_r == S_WALK && idx_r == '0))
    else $error("walk did not start at slot zero");
`endif

endmodule

// ----- tb/buffer_slot_manager_age_evict_tb.sv -----
// ----------------------------------------------------------------------------
// buffer_slot_manager_age_evict_tb
// Self-checking bench for the buffer slot manager. A behavioral copy of the
// slot pool (free, dirty, tag, age per slot) predicts the result of each
// accepted request. The bench runs directed corner requests, fills the pool
// and forces evictions with write-back, then runs mostly well-formed random
// traffic with random idle bursts on both channels, a long output hold-off
// and a full drain pause.
// ----------------------------------------------------------------------------
module buffer_slot_manager_age_evict_tb
  import bsm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]       OP_UNUSED    = 2'd3;
  localparam logic [BLK_W-1:0] LAST_BLOCK   = BLK_W'(DISK_BLOCK_COUNT - 1);
  localparam int               NARROW_RANGE = 40;
  localparam int               LONG_HOLD    = 300;
  localparam int               DRAIN_LIMIT  = 50000;
  localparam int               SETTLE       = 40;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Shadow copy of the slot pool
  logic             pool_free  [SLOT_COUNT];
  logic             pool_dirty [SLOT_COUNT];
  logic [BLK_W-1:0] pool_tag   [SLOT_COUNT];
  logic [AGE_W-1:0] pool_age   [SLOT_COUNT];

  out_item_t   pending_results[$];
  int unsigned n_errors     = 0;
  int unsigned n_requests   = 0;
  int unsigned n_results    = 0;
  int unsigned n_oob        = 0;
  int unsigned n_miss       = 0;
  int unsigned n_evict_wb   = 0;
  bit          tx_gaps_on   = 1'b0;
  bit          rx_stalls_on = 1'b0;
  int unsigned hold_left    = 0;

  buffer_slot_manager_age_evict u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("buffer_slot_manager_age_evict_tb: FAIL");
    $finish;
  end

  // Update the shadow pool for one request and return its result
  function automatic out_item_t predict_request(input in_item_t req);
    out_item_t res;
    int        pick;
    int        best;
    res = '0;
    if (req.block_num == 0 || int'(req.block_num) >= DISK_BLOCK_COUNT) begin
      res.status = ST_OOB;
    end else if (req.op == OP_ALLOC) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (!pool_free[i] && pool_age[i] != AGE_MAX) pool_age[i] = pool_age[i] + 1'b1;
      end
      pick = -1;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
        if (pool_free[i]) pick = i;
      end
      // pool full: oldest slot, lowest index wins a tie
      if (pick < 0) begin
        best = -1;
        pick = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (int'(pool_age[i]) > best) begin
            best = int'(pool_age[i]);
            pick = i;
          end
        end
        if (pool_dirty[pick]) begin
          res.writeback_valid = 1'b1;
          res.writeback_block = pool_tag[pick];
        end
      end
      pool_free[pick]  = 1'b0;
      pool_dirty[pick] = 1'b0;
      pool_tag[pick]   = req.block_num;
      pool_age[pick]   = '0;
      res.slot_index   = 5'(pick);
    end else begin
      // lookup, mark dirty and the unused code: lowest occupied slot with the tag
      pick = -1;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
        if (!pool_free[i] && pool_tag[i] == req.block_num) pick = i;
      end
      if (pick < 0) begin
        res.status = ST_MISS;
      end else begin
        if (req.op == OP_MARK) pool_dirty[pick] = 1'b1;
        res.slot_index = 5'(pick);
      end
    end
    return res;
  endfunction

  function automatic in_item_t make_req(input logic [1:0] op, input logic [BLK_W-1:0] blk);
    in_item_t req;
    req.op        = op;
    req.block_num = blk;
    return req;
  endfunction

  function automatic logic [BLK_W-1:0] random_block(input bit narrow);
    if (narrow) return BLK_W'($urandom_range(1, NARROW_RANGE));
    return BLK_W'($urandom_range(1, DISK_BLOCK_COUNT - 1));
  endfunction

  // Tag of a random occupied slot, or a fresh block while the pool is empty
  function automatic logic [BLK_W-1:0] held_block(input bit narrow);
    int occupied[$];
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!pool_free[i]) occupied.push_back(i);
    end
    if (occupied.size() == 0) return random_block(narrow);
    return pool_tag[occupied[$urandom_range(0, occupied.size() - 1)]];
  endfunction

  function automatic bit pool_has_free();
    bit found;
    found = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (pool_free[i]) found = 1'b1;
    end
    return found;
  endfunction

  // Mostly well-formed requests, lookups and marks mostly at held blocks; the rest is noise
  function automatic in_item_t random_request(input int unsigned noise_pct, input bit narrow);
    in_item_t    req;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < noise_pct) begin
      req.op = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0:       req.block_num = '0;
        1:       req.block_num = BLK_W'($urandom());
        default: req.block_num = LAST_BLOCK;
      endcase
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        req.op        = OP_ALLOC;
        req.block_num = ($urandom_range(0, 6) == 0) ? held_block(narrow) : random_block(narrow);
      end else begin
        req.op        = (roll < 70) ? OP_LOOKUP : OP_MARK;
        req.block_num = ($urandom_range(0, 6) == 0) ? random_block(narrow) : held_block(narrow);
      end
    end
    return req;
  endfunction

  // Offer one transaction, hold it until accepted, then record its result
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_request(req));
    n_requests++;
  endtask

  task automatic wait_all_results();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_errors++;
    end
  endtask

  // Output stall: long hold-off on request, else random stall bursts
  initial begin
    int unsigned burst_left;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left != 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d slot %0d",
               out_data.status, out_data.slot_index);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (want.status == ST_OOB) n_oob++;
        if (want.status == ST_MISS) n_miss++;
        if (want.writeback_valid) n_evict_wb++;
        report_field("status", want.status, out_data.status);
        report_field("slot_index", want.slot_index, out_data.slot_index);
        report_field("writeback_valid", want.writeback_valid, out_data.writeback_valid);
        report_field("writeback_block", want.writeback_block, out_data.writeback_block);
      end
    end
  end

  // Out-of-range blocks, misses, first allocations, duplicates, unused code
  task automatic test_directed();
    send_request(make_req(OP_LOOKUP, '0));
    send_request(make_req(OP_ALLOC, '0));
    send_request(make_req(OP_MARK, '0));
    send_request(make_req(OP_UNUSED, '0));
    send_request(make_req(OP_LOOKUP, 13'd5));
    send_request(make_req(OP_MARK, 13'd5));
    send_request(make_req(OP_ALLOC, LAST_BLOCK));
    send_request(make_req(OP_ALLOC, 13'd1));
    send_request(make_req(OP_ALLOC, 13'h1555));
    send_request(make_req(OP_ALLOC, 13'h0AAA));
    send_request(make_req(OP_LOOKUP, LAST_BLOCK));
    send_request(make_req(OP_UNUSED, 13'd1));
    send_request(make_req(OP_MARK, 13'h1555));
    // second copy of a held block: lookups keep hitting the lower slot
    send_request(make_req(OP_ALLOC, LAST_BLOCK));
    send_request(make_req(OP_LOOKUP, LAST_BLOCK));
    send_request(make_req(OP_MARK, LAST_BLOCK));
    send_request(make_req(OP_UNUSED, 13'd2));
    send_request(make_req(OP_LOOKUP, 13'd2));
  endtask

  // Fill the pool, then mix marks and allocations to evict dirty slots
  task automatic test_evict();
    while (pool_has_free()) send_request(make_req(OP_ALLOC, random_block(1'b0)));
    for (int i = 0; i < 60; i++) begin
      if (i % 2 == 0) send_request(make_req(OP_MARK, held_block(1'b0)));
      else send_request(make_req(OP_ALLOC, random_block(1'b0)));
    end
  endtask

  task automatic test_random(input int unsigned count, input bit narrow);
    for (int i = 0; i < count; i++) send_request(random_request(10, narrow));
  endtask

  // Hold the output off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    hold_left  = LONG_HOLD;
    test_random(40, 1'b0);
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    wait_all_results();
    test_random(300, 1'b0);
  endtask

  task automatic test_no_idle();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    test_random(400, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pool_free[i]  = 1'b1;
      pool_dirty[i] = 1'b0;
      pool_tag[i]   = '0;
      pool_age[i]   = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    test_directed();
    test_evict();
    test_random(700, 1'b0);
    test_random(400, 1'b1);
    test_backpressure();
    test_drain_pause();
    test_no_idle();
    wait_all_results();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests and %0d results: %0d out of range, %0d misses,",
             n_requests, n_results, n_oob, n_miss);
    $display("%0d dirty evictions, a long output hold-off and a full drain pause.",
             n_evict_wb);
    if (n_errors == 0) begin
      $display("buffer_slot_manager_age_evict_tb: PASS");
    end else begin
      $display("buffer_slot_manager_age_evict_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bsm_pkg.sv
hdl/bsm_slot_store.sv
hdl/bsm_scan_unit.sv
hdl/buffer_slot_manager_age_evict.sv
tb/buffer_slot_manager_age_evict_tb.sv
